@@ rtl/assert_macros.svh @@
// assertion macros shared by the checker files
// each macro takes a label, a clock, a reset and the property terms
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/itgt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itgt_pkg
// Shared types and constants for the grouped decimal text formatter.
// ----------------------------------------------------------------------------
package itgt_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
   localparam int unsigned PROD_W     = 2 * DATA_W;
   // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for any 32-bit x
   localparam logic [DATA_W-1:0] RECIP10 = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_WAIT,
      ST_EMIT
   } itgt_state_type;

   // request into the shared divide-by-ten unit
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
   } itgt_div_req_type;

   // result out of the shared divide-by-ten unit
   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quot;
      logic [3:0]        rem;
   } itgt_div_rsp_type;

   // one character offered by the sequencer
   typedef struct packed {
      logic       valid;
      logic [7:0] ch;
      logic       last;
   } itgt_char_type;

   // a comma follows the digit at this position (counted from the right, from 0)
   function automatic logic group_end(input logic [DIG_IDX_W-1:0] idx);
      logic hit;
      unique case (idx)
         4'd3, 4'd6, 4'd9: hit = 1'b1;
         default:          hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

@@ rtl/itgt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itgt_if
// Valid/ready channels for the integer request and the character response.
// ----------------------------------------------------------------------------
interface itgt_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itgt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

@@ rtl/itgt_div10.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itgt_div10
// Shared divide-by-ten unit: reciprocal multiply, then remainder correction.
// ----------------------------------------------------------------------------
module itgt_div10 (
   input  logic                       clock,
   input  logic                       reset,
   input  itgt_pkg::itgt_div_req_type div_req,
   output itgt_pkg::itgt_div_rsp_type div_rsp
);
   import itgt_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DATA_W-1:0] dvd_ff;
   logic              done_ff, done_in;
   logic [DATA_W-1:0] quot;
   logic [DATA_W-1:0] quot_x10;
   logic [DATA_W-1:0] diff;

   // reciprocal product, registered before the correction step
   assign prod_in = PROD_W'(div_req.dividend) * PROD_W'(RECIP10);
   assign done_in = div_req.start;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         prod_ff <= prod_in;
         dvd_ff  <= div_req.dividend;
      end
   end

   // quotient from the high product bits, remainder by shift-add back
   assign quot     = DATA_W'(prod_ff >> RECIP_SHIFT);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign diff     = dvd_ff - quot_x10;

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot;
   assign div_rsp.rem  = diff[3:0];

endmodule

@@ rtl/itgt_fmt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itgt_fmt
// Sequencer: peels digits with the shared divider, then walks them out
// most significant first with sign and group commas.
// ----------------------------------------------------------------------------
module itgt_fmt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic signed [31:0]         in_value,
   output logic                       in_ready,
   output itgt_pkg::itgt_div_req_type div_req,
   input  itgt_pkg::itgt_div_rsp_type div_rsp,
   output itgt_pkg::itgt_char_type    out_char,
   input  logic                       take
);
   import itgt_pkg::*;

   itgt_state_type       state_ff, state_in;
   logic [DATA_W-1:0]    mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [DIG_IDX_W-1:0] ndig_ff, ndig_in;
   logic [DIG_IDX_W-1:0] idx_ff, idx_in;
   logic                 sign_ff, sign_in;
   logic                 comma_ff, comma_in;
   logic [3:0]           digits_ff [MAX_DIGITS];
   logic                 digit_wr;
   logic                 final_char;

   assign digit_wr   = (state_ff == ST_WAIT) && div_rsp.done;
   assign final_char = !sign_ff && !comma_ff && (idx_ff == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) state_in = (div_rsp.quot == '0) ? ST_EMIT : ST_DIV;
         end
         ST_EMIT: begin
            if (take && final_char) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      ndig_in  = ndig_ff;
      idx_in   = idx_ff;
      sign_in  = sign_ff;
      comma_in = comma_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               neg_in  = in_value[31];
               mag_in  = in_value[31] ? (DATA_W'(0) - $unsigned(in_value)) : $unsigned(in_value);
               ndig_in = '0;
            end
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               mag_in  = div_rsp.quot;
               ndig_in = ndig_ff + 1'b1;
               if (div_rsp.quot == '0) begin
                  idx_in   = ndig_ff;
                  sign_in  = neg_ff;
                  comma_in = 1'b0;
               end
            end
         end
         ST_EMIT: begin
            if (take) begin
               priority if (sign_ff) begin
                  sign_in = 1'b0;
               end else if (comma_ff) begin
                  comma_in = 1'b0;
                  idx_in   = idx_ff - 1'b1;
               end else if (idx_ff != '0) begin
                  if (group_end(idx_ff)) comma_in = 1'b1;
                  else                   idx_in   = idx_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      in_ready         = (state_ff == ST_IDLE);
      div_req.start    = (state_ff == ST_DIV);
      div_req.dividend = mag_ff;
      out_char.valid   = (state_ff == ST_EMIT);
      out_char.last    = final_char;
      priority if (sign_ff)  out_char.ch = CH_MINUS;
      else if (comma_ff)     out_char.ch = CH_COMMA;
      else                   out_char.ch = CH_ZERO + {4'b0, digits_ff[idx_ff]};
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sign_ff  <= 1'b0;
         comma_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sign_ff  <= sign_in;
         comma_ff <= comma_in;
      end
   end

   // payload registers and digit store, least significant digit at entry 0
   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      ndig_ff <= ndig_in;
      idx_ff  <= idx_in;
      if (digit_wr) begin
         digits_ff[ndig_ff] <= div_rsp.rem;
      end
   end

endmodule

@@ rtl/int_to_decimal_grouped_text.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_grouped_text
// Signed 32-bit integer in, grouped decimal ASCII text out, one char a word.
// ----------------------------------------------------------------------------
// Each request word carries one signed integer; the response stream gives its
// text most significant character first, e.g. -1234567 -> "-1,234,567", with
// last set on the final character. An item's digits come off one at a time,
// least significant first, from a single shared divide-by-ten unit
// (reciprocal multiply, registered, then remainder step); then its characters
// leave one per cycle while the response side is not stalled. The request
// side is not ready while an item is in progress; a registered response
// stage lets the next item start while the final character still waits to be
// taken.
module int_to_decimal_grouped_text (
   input  logic      clock,
   input  logic      reset,
   itgt_req_if.sink  req,
   itgt_rsp_if.source rsp
);
   import itgt_pkg::*;

   itgt_div_req_type div_req;
   itgt_div_rsp_type div_rsp;
   itgt_char_type    fmt_char;
   logic             take;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_ch_ff;
   logic             rsp_last_ff;

   itgt_div10 u_div10 (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   itgt_fmt u_fmt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_value (req.value),
      .in_ready (req.ready),
      .div_req  (div_req),
      .div_rsp  (div_rsp),
      .out_char (fmt_char),
      .take     (take)
   );

   // response register: refill when empty or being drained
   assign take         = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = take ? fmt_char.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && fmt_char.valid) begin
         rsp_ch_ff   <= fmt_char.ch;
         rsp_last_ff <= fmt_char.last;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.ch    = rsp_ch_ff;
   assign rsp.last  = rsp_last_ff;

endmodule

@@ rtl/itgt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itgt_checker
// Port-level checks on the grouped decimal text formatter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itgt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_ch,
   input logic       rsp_last
);
   import itgt_pkg::*;

   // a stalled response word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_ch) && $stable(rsp_last))

   // one item at a time: busy right after an accept
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // only sign, comma or digit characters appear
   `ASSERT_IMPLY(a_legal_char, clock, reset, rsp_valid, (rsp_ch == CH_MINUS) || (rsp_ch == CH_COMMA) || ((rsp_ch >= CH_ZERO) && (rsp_ch <= CH_NINE)))

   // text always ends on a digit, never on a sign or comma
   `ASSERT_IMPLY(a_end_on_digit, clock, reset, rsp_valid && rsp_last, (rsp_ch >= CH_ZERO) && (rsp_ch <= CH_NINE))

endmodule

bind int_to_decimal_grouped_text itgt_checker u_itgt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_ch    (rsp.ch),
   .rsp_last  (rsp.last)
);

@@ bench/itgt_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itgt_scoreboard_pkg
// Expected grouped decimal text for each accepted integer, checked in order.
// ----------------------------------------------------------------------------
// note_value() formats an accepted integer the way the formatter should:
// optional minus sign, digits in groups of three from the right with commas
// between groups, last mark on the final character. check_char() pops the
// oldest expected character and compares it with what came out.
package itgt_scoreboard_pkg;

   import itgt_pkg::*;

   localparam int unsigned GROUP_SIZE = 3;
   localparam int unsigned MAX_CHARS  = 14;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   class text_scoreboard;
      text_char_type pending_chars[$];
      int unsigned   mismatches;

      function new();
         mismatches = 0;
      endfunction

      // expected text of one accepted integer, most significant char first
      function void note_value(input logic [31:0] raw);
         logic        neg;
         logic [31:0] mag;
         logic [7:0]  rev_text[$];
         int unsigned digits;
         text_char_type c;

         neg    = raw[31];
         // magnitude in unsigned arithmetic covers the most negative value
         mag    = neg ? (32'd0 - raw) : raw;
         digits = 0;
         // build backwards: a comma ahead of every group after the first
         do begin
            if (digits != 0 && (digits % GROUP_SIZE) == 0) begin
               rev_text.push_back(CH_COMMA);
            end
            rev_text.push_back(CH_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
            digits++;
         end while (mag != 0 && rev_text.size() < MAX_CHARS - 1);
         // minus sign never counts as a digit, so no comma follows it
         if (neg && rev_text.size() < MAX_CHARS) begin
            rev_text.push_back(CH_MINUS);
         end
         for (int i = rev_text.size() - 1; i >= 0; i--) begin
            c.ch   = rev_text[i];
            c.last = (i == 0);
            pending_chars.push_back(c);
         end
      endfunction

      task report_mismatch(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // compare one output word against the oldest expectation
      task check_char(input logic [7:0] ch, input logic last);
         text_char_type want;

         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
            return;
         end
         want = pending_chars.pop_front();
         if (ch !== want.ch) begin
            report_mismatch($sformatf("ch 0x%02h, expected 0x%02h", ch, want.ch));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b (ch 0x%02h)",
                                      last, want.last, want.ch));
         end
      endtask

      function int unsigned pending_count();
         return pending_chars.size();
      endfunction
   endclass

endpackage

@@ bench/tb_int_to_decimal_grouped_text.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int_to_decimal_grouped_text
// Self-checking bench for the grouped decimal text formatter.
// ----------------------------------------------------------------------------
// Sends a directed set of integers (zero, sign and group boundaries, both
// 32-bit extremes) and then random integers of every magnitude and sign.
// Each response word is checked against the scoreboard's expected text.
// Both sides pause in random bursts except during the final stretch, and the
// sender drains the block twice.
module tb_int_to_decimal_grouped_text;

   import itgt_pkg::*;
   import itgt_scoreboard_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 470;
   localparam int unsigned CALM_ITEMS   = 70;
   localparam int unsigned DRAIN_AT     = 200;
   localparam int unsigned TAIL_CYCLES  = 50;

   logic clock;
   logic reset;
   bit   calm;

   itgt_req_if req_ch ();
   itgt_rsp_if rsp_ch ();

   text_scoreboard sb;

   int directed_values[] = '{
      0, 1, -1, 7, 10, -10, 99, 100, -999, 1000, -1000, 123456, -999999,
      1000000, 12345678, -123456789, 999999999, 1000000000, 2147483647,
      -2147483647, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
   };

   int_to_decimal_grouped_text i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("int_to_decimal_grouped_text verification failed");
      $finish;
   end

   // offer one integer and hold it until the block takes the word
   task automatic send_value(input logic [31:0] v);
      req_ch.valid = 1'b1;
      req_ch.value = v;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_value(v);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      req_ch.valid = 1'b0;
      req_ch.value = $urandom;
      repeat (cycles) @(negedge clock);
   endtask

   // hold off until every expected char has come out
   task automatic drain_block();
      idle_sender(1);
      while (sb.pending_count() != 0) @(negedge clock);
   endtask

   // response side: random stall bursts, none once calm
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(1, 24)) @(negedge clock);
      end
   end

   // check each accepted response word
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_char(rsp_ch.ch, rsp_ch.last);
      end
   end

   // stimulus
   initial begin
      logic [31:0] v;
      logic [31:0] p;

      sb           = new();
      calm         = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed values
      foreach (directed_values[i]) begin
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 11));
         send_value(directed_values[i]);
      end
      drain_block();

      // random values spread over all magnitudes
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == DRAIN_AT) drain_block();
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (!calm && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 11));
         case ($urandom_range(0, 7))
            0: v = $urandom;
            1: begin
               // just below or at a power of ten
               p = 32'd1;
               repeat ($urandom_range(0, 9)) p = p * 32'd10;
               v = p - 32'($urandom_range(0, 1));
            end
            default: v = $urandom >> $urandom_range(0, 31);
         endcase
         if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
         send_value(v);
      end
      req_ch.valid = 1'b0;

      // wait for the tail of the text, then settle
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("int_to_decimal_grouped_text verification clean");
      end else begin
         $display("int_to_decimal_grouped_text verification failed");
      end
      $finish;
   end

endmodule
